FILE: hw/rtl/asfx_pkg.sv
// Shared types and constants for the audio sample effect unit.
package asfx_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int MODE_W     = 3;
  localparam int DELAY_W    = 14;
  localparam int FILL_W     = 15;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic [FILL_W-1:0]          FILL_MAX   = 15'h7FFF;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLIP      = 3'd0,
    MODE_HALF_RECT = 3'd1,
    MODE_FULL_RECT = 3'd2,
    MODE_ECHO      = 3'd3,
    MODE_ECHO_NEG  = 3'd4
  } mode_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_EFFECT_MODE   = 2'd0,
    REG_DELAY_SAMPLES = 2'd1,
    REG_ECHO_GAIN     = 2'd2
  } reg_idx_t;

  localparam mode_t                      RST_EFFECT_MODE   = MODE_CLIP;
  localparam logic [DELAY_W-1:0]         RST_DELAY_SAMPLES = 14'd12600;
  localparam logic signed [SAMPLE_W-1:0] RST_ECHO_GAIN     = 16'sd14746;

endpackage

FILE: hw/rtl/audio_sample_effect_unit.sv
// Top level of the audio sample effect unit: clip, rectify and feedforward comb echo.
//
// The unit takes one signed 16-bit sample per request and returns one processed sample.
// It accepts a new sample every clock cycle unless out_tready stalls the output. A
// sample goes from the stage 1 register to the output register. The RAM sets the rate:
// one write (the new sample) and one read (the delayed sample) in every accepted cycle.
// An echo adds the sample from delay_samples earlier times a Q1.15 gain and saturates
// to 16 bits; until delay_samples samples have passed since a buffer start, echo modes
// pass the input through. Delays at or beyond the line depth use DELAY_DEPTH-1.
module audio_sample_effect_unit #(
  parameter int DELAY_DEPTH = 16384
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [asfx_pkg::SAMPLE_W-1:0]     in_tdata,   // [15:0] in_sample
  input  logic                              in_tuser,   // [0] buffer_start
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [asfx_pkg::SAMPLE_W-1:0]     out_tdata,  // [15:0] out_sample
  // Configuration writes.
  input  logic                              cfg_we,
  input  logic [asfx_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [asfx_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int DX = 18;  // wide enough for any delay, pointer or depth value

  // Configuration registers.
  asfx_pkg::mode_t                              effect_mode_r;
  logic [asfx_pkg::DELAY_W-1:0]                 delay_samples_r;
  logic signed [asfx_pkg::SAMPLE_W-1:0]         echo_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      effect_mode_r   <= asfx_pkg::RST_EFFECT_MODE;
      delay_samples_r <= asfx_pkg::RST_DELAY_SAMPLES;
      echo_gain_r     <= asfx_pkg::RST_ECHO_GAIN;
    end else if (cfg_we) begin
      case (asfx_pkg::reg_idx_t'(cfg_addr))
        asfx_pkg::REG_EFFECT_MODE: begin
          effect_mode_r <= asfx_pkg::mode_t'(cfg_wdata[asfx_pkg::MODE_W-1:0]);
        end
        asfx_pkg::REG_DELAY_SAMPLES: begin
          delay_samples_r <= cfg_wdata[asfx_pkg::DELAY_W-1:0];
        end
        asfx_pkg::REG_ECHO_GAIN: begin
          echo_gain_r <= cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  // Pipeline control.
  logic s1_valid_r;
  logic out_valid_r;
  logic out_adv;
  logic in_acc;

  assign out_adv   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_adv;
  assign in_acc    = in_tvalid && in_tready;

  // Delay line addressing and fill count.
  logic [AW-1:0]                wr_ptr_r;
  logic [AW-1:0]                wr_ptr_nxt;
  logic [asfx_pkg::FILL_W-1:0]  fill_r;
  logic [asfx_pkg::FILL_W-1:0]  fill_nxt;
  logic [asfx_pkg::FILL_W-1:0]  seen;
  logic [DX-1:0]                d_ext;
  logic [DX-1:0]                d_sat;
  logic [DX-1:0]                ptr_ext;
  logic [DX-1:0]                rd_ext;
  logic [AW-1:0]                rd_addr;
  logic                         warm;
  logic                         d_zero;

  always_comb begin
    d_ext   = DX'(delay_samples_r);
    d_sat   = (d_ext > DX'(DELAY_DEPTH - 1)) ? DX'(DELAY_DEPTH - 1) : d_ext;
    d_zero  = (d_sat == '0);
    ptr_ext = DX'(wr_ptr_r);
    // Circular subtraction: wrap by adding the depth when the pointer is behind.
    rd_ext  = (ptr_ext < d_sat) ? (ptr_ext + DX'(DELAY_DEPTH) - d_sat) : (ptr_ext - d_sat);
    rd_addr = rd_ext[AW-1:0];

    seen     = in_tuser ? '0 : fill_r;
    warm     = (DX'(seen) < d_sat);
    fill_nxt = (seen == asfx_pkg::FILL_MAX) ? asfx_pkg::FILL_MAX : seen + 1'b1;
    wr_ptr_nxt = (ptr_ext == DX'(DELAY_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      fill_r   <= '0;
    end else if (in_acc) begin
      wr_ptr_r <= wr_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  logic [asfx_pkg::SAMPLE_W-1:0] ram_q;

  asfx_ram #(
    .WIDTH (asfx_pkg::SAMPLE_W),
    .DEPTH (DELAY_DEPTH)
  ) u_delay_line (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (wr_ptr_r),
    .wr_data (in_tdata),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // Stage 1: sample and flags, alongside the RAM read data.
  logic signed [asfx_pkg::SAMPLE_W-1:0] s1_x_r;
  logic                                 s1_warm_r;
  logic                                 s1_dzero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r     <= in_tdata;
      s1_warm_r  <= warm;
      s1_dzero_r <= d_zero;
    end
  end

  // Effect datapath.
  logic signed [asfx_pkg::SAMPLE_W-1:0] xd;
  logic signed [asfx_pkg::SAMPLE_W:0]   g_eff;
  logic signed [32:0]                   prod;
  logic signed [33:0]                   acc;
  logic signed [19:0]                   quo;
  logic signed [asfx_pkg::SAMPLE_W-1:0] echo_y;
  logic signed [asfx_pkg::SAMPLE_W-1:0] y;

  always_comb begin
    xd    = s1_dzero_r ? s1_x_r : $signed(ram_q);
    g_eff = (effect_mode_r == asfx_pkg::MODE_ECHO_NEG) ? -17'(echo_gain_r)
                                                       : 17'(echo_gain_r);
    prod  = g_eff * xd;
    acc   = (34'(s1_x_r) <<< 15) + 34'(prod);
    // Divide by 2^15 rounding toward zero.
    quo   = 20'(acc >>> 15) + 20'((acc < 0) && (acc[14:0] != '0));
    if (quo > 20'(asfx_pkg::SAMPLE_MAX)) begin
      echo_y = asfx_pkg::SAMPLE_MAX;
    end else if (quo < 20'(asfx_pkg::SAMPLE_MIN)) begin
      echo_y = asfx_pkg::SAMPLE_MIN;
    end else begin
      echo_y = quo[asfx_pkg::SAMPLE_W-1:0];
    end

    case (effect_mode_r)
      asfx_pkg::MODE_CLIP: begin
        y = s1_x_r[asfx_pkg::SAMPLE_W-1] ? '0 : asfx_pkg::SAMPLE_MAX;
      end
      asfx_pkg::MODE_HALF_RECT: begin
        y = s1_x_r[asfx_pkg::SAMPLE_W-1] ? '0 : s1_x_r;
      end
      asfx_pkg::MODE_FULL_RECT: begin
        if (s1_x_r == asfx_pkg::SAMPLE_MIN) begin
          y = asfx_pkg::SAMPLE_MAX;
        end else begin
          y = s1_x_r[asfx_pkg::SAMPLE_W-1] ? -s1_x_r : s1_x_r;
        end
      end
      asfx_pkg::MODE_ECHO, asfx_pkg::MODE_ECHO_NEG: begin
        y = s1_warm_r ? s1_x_r : echo_y;
      end
      default: begin
        y = s1_x_r;
      end
    endcase
  end

  // Output register.
  logic [asfx_pkg::SAMPLE_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_data_r <= y;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: hw/rtl/asfx_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module asfx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
